/* rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Arena geometry, header layout and opcodes shared by the allocator RTL.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ARENA_BYTES = 16384;
	localparam int HDR_BYTES   = 4;
	localparam int WORDS       = ARENA_BYTES / HDR_BYTES;
	localparam int OFF_W       = $clog2(ARENA_BYTES);
	localparam int SZ_W        = OFF_W + 1;
	localparam int IDX_W       = $clog2(WORDS);
	localparam int ALU_W       = SZ_W + 2;

	localparam int REQ_W   = 15;
	localparam int LIMIT_W = 15;
	localparam int FOFF_W  = 14;
	localparam int DOFF_W  = 14;

	// rounding: ((req + 3) & ~3) + 4 == (req + 7) & ~3
	localparam int ROUND_ADD = 7;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(ARENA_BYTES);

	typedef struct packed {
		logic            last;
		logic            used;
		logic [SZ_W-1:0] size;
	} hdr_t;

endpackage

/* rtl/first_fit_heap_allocator_unit.sv */
// Sequence: accept, walk the block headers, write the header updates, then load the
// result register; ok=0 items go straight to the load from the failing check.
// A result held by m_tready low stalls the next item in the load.
// Flow: one item at a time, as s_tready is low from accept until the result is loaded;
// the walk is paced by the single read port of the header memory (one header per cycle).
// Reset: arst_n clears control state and arena top at once; limit resets to ARENA_BYTES.
// ----------------------------------------------------------------------------
// First-fit heap allocator unit
// Walks a chain of block headers held in a memory, one header per cycle, under a
// small sequencer sharing a single add/subtract unit; allocates first-fit with
// split and end growth, frees with forward and backward merge.
// The header memory is not cleared, only headers already written are ever used.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ffha_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // [14:0] request_bytes, [28:15] free_offset
	input  logic                           s_tuser,  // [0] op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,  // [13:0] data_offset
	output logic                           m_tuser   // [0] ok
);

	localparam int OFF_W = ffha_pkg::OFF_W;
	localparam int SZ_W  = ffha_pkg::SZ_W;
	localparam int IDX_W = ffha_pkg::IDX_W;
	localparam int ALU_W = ffha_pkg::ALU_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_WALK,
		ST_A_SPL1,
		ST_A_SPL2,
		ST_A_SPL3,
		ST_A_APP,
		ST_A_NEW,
		ST_F_WALK,
		ST_F_MRG,
		ST_F_PRV,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [OFF_W-1:0]                p_q;
	logic [OFF_W-1:0]                target_q;
	logic [OFF_W-1:0]                prev_q;
	ffha_pkg::hdr_t                  prev_hdr_q;
	logic                            have_prev_q;
	logic [SZ_W:0]                   nsize_q;
	logic [SZ_W-1:0]                 rem_q;
	logic [SZ_W-1:0]                 sz_q;
	logic                            last_q;
	logic [SZ_W-1:0]                 arena_top_q;
	logic                            list_started_q;
	logic [ffha_pkg::LIMIT_W-1:0]    limit_q;
	logic                            res_ok_q;
	logic [ffha_pkg::DOFF_W-1:0]     res_off_q;
	logic                            out_valid_q;
	logic                            out_ok_q;
	logic [ffha_pkg::DOFF_W-1:0]     out_off_q;

	ffha_pkg::hdr_t                  hdr_mem [ffha_pkg::WORDS];
	ffha_pkg::hdr_t                  rd_hdr_q;
	logic                            rd_en;
	logic [IDX_W-1:0]                rd_idx;
	logic                            wr_en;
	logic [IDX_W-1:0]                wr_idx;
	ffha_pkg::hdr_t                  wr_hdr;

	logic [ALU_W-1:0]                alu_a;
	logic [ALU_W-1:0]                alu_b;
	logic                            alu_sub;
	logic [ALU_W-1:0]                alu_y;

	logic [ffha_pkg::REQ_W-1:0]      req_bytes;
	logic [ffha_pkg::FOFF_W-1:0]     free_off;
	logic [SZ_W-1:0]                 limit_eff;
	logic [SZ_W-1:0]                 sz;
	logic                            a_fit;
	logic                            a_split;
	logic                            a_stop;
	logic                            f_hit;
	logic                            f_stop;
	logic                            over;
	logic                            free_ok;
	logic                            mrg;
	logic [SZ_W-1:0]                 mrg_size;
	logic                            mrg_last;
	logic [OFF_W-1:0]                p_data;
	logic [OFF_W-1:0]                end_data;

	assign req_bytes = s_tdata[ffha_pkg::REQ_W-1:0];
	assign free_off  = s_tdata[ffha_pkg::REQ_W +: ffha_pkg::FOFF_W];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {{(16 - ffha_pkg::DOFF_W){1'b0}}, out_off_q};

	// shared add/subtract unit
	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	assign limit_eff = (limit_q > SZ_W'(ffha_pkg::ARENA_BYTES)) ?
		SZ_W'(ffha_pkg::ARENA_BYTES) : SZ_W'(limit_q);
	assign sz       = rd_hdr_q.size;
	assign a_fit    = !rd_hdr_q.used && ({1'b0, sz} >= nsize_q);
	assign a_split  = {1'b0, sz} > nsize_q;
	assign a_stop   = rd_hdr_q.last || (sz == '0) || (alu_y >= ALU_W'(arena_top_q));
	assign f_hit    = (p_q == target_q);
	assign f_stop   = rd_hdr_q.last || (sz == '0) || (p_q > target_q);
	assign over     = alu_y > ALU_W'(limit_eff);
	assign free_ok  = list_started_q && (free_off >= ffha_pkg::FOFF_W'(ffha_pkg::HDR_BYTES))
		&& (free_off[1:0] == 2'b00);
	assign mrg      = !last_q && !rd_hdr_q.used;
	assign mrg_size = mrg ? alu_y[SZ_W-1:0] : sz_q;
	assign mrg_last = mrg ? rd_hdr_q.last : last_q;
	assign p_data   = {p_q[OFF_W-1:2] + (OFF_W-2)'(1), 2'b00};
	assign end_data = {arena_top_q[OFF_W-1:2] + (OFF_W-2)'(1), 2'b00};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		rd_en   = 1'b0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = p_q[OFF_W-1:2];
		wr_hdr  = '0;
		case (state_q)
			ST_IDLE: begin
				rd_en = s_tvalid;
				if (s_tuser == ffha_pkg::OP_FREE) begin
					alu_a   = ALU_W'(free_off);
					alu_b   = ALU_W'(ffha_pkg::HDR_BYTES);
					alu_sub = 1'b1;
				end else begin
					alu_a = ALU_W'(req_bytes);
					alu_b = ALU_W'(ffha_pkg::ROUND_ADD);
				end
			end
			ST_A_WALK: begin
				alu_a = ALU_W'(p_q);
				alu_b = ALU_W'(sz);
				if (a_fit) begin
					if (!a_split) begin
						wr_en  = 1'b1;
						wr_hdr = '{last: rd_hdr_q.last, used: 1'b1, size: sz};
					end
				end else if (!a_stop) begin
					rd_en  = 1'b1;
					rd_idx = alu_y[OFF_W-1:2];
				end
			end
			ST_A_SPL1: begin
				alu_a   = ALU_W'(sz);
				alu_b   = ALU_W'(nsize_q);
				alu_sub = 1'b1;
			end
			ST_A_SPL2: begin
				alu_a  = ALU_W'(p_q);
				alu_b  = ALU_W'(nsize_q);
				wr_en  = 1'b1;
				wr_idx = alu_y[OFF_W-1:2];
				wr_hdr = '{last: rd_hdr_q.last, used: 1'b0, size: rem_q};
			end
			ST_A_SPL3: begin
				wr_en  = 1'b1;
				wr_hdr = '{last: 1'b0, used: 1'b1, size: nsize_q[SZ_W-1:0]};
			end
			ST_A_APP: begin
				alu_a = ALU_W'(arena_top_q);
				alu_b = ALU_W'(nsize_q);
				if (!over && list_started_q) begin
					wr_en  = 1'b1;
					wr_hdr = '{last: 1'b0, used: rd_hdr_q.used, size: sz};
				end
			end
			ST_A_NEW: begin
				alu_a  = ALU_W'(arena_top_q);
				alu_b  = ALU_W'(nsize_q);
				wr_en  = 1'b1;
				wr_idx = arena_top_q[OFF_W-1:2];
				wr_hdr = '{last: 1'b1, used: 1'b1, size: nsize_q[SZ_W-1:0]};
			end
			ST_F_WALK: begin
				alu_a = ALU_W'(p_q);
				alu_b = ALU_W'(sz);
				if (f_hit) begin
					if (rd_hdr_q.used && !rd_hdr_q.last) begin
						rd_en  = 1'b1;
						rd_idx = alu_y[OFF_W-1:2];
					end
				end else if (!f_stop) begin
					rd_en  = 1'b1;
					rd_idx = alu_y[OFF_W-1:2];
				end
			end
			ST_F_MRG: begin
				alu_a  = ALU_W'(sz_q);
				alu_b  = ALU_W'(sz);
				wr_en  = 1'b1;
				wr_hdr = '{last: mrg_last, used: 1'b0, size: mrg_size};
			end
			ST_F_PRV: begin
				alu_a  = ALU_W'(prev_hdr_q.size);
				alu_b  = ALU_W'(sz_q);
				wr_idx = prev_q[OFF_W-1:2];
				if (have_prev_q && !prev_hdr_q.used) begin
					wr_en  = 1'b1;
					wr_hdr = '{last: last_q, used: 1'b0, size: alu_y[SZ_W-1:0]};
				end
			end
			default: begin
			end
		endcase
	end

	// header memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hdr_mem[wr_idx] <= wr_hdr;
		end
		if (rd_en) begin
			rd_hdr_q <= hdr_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			arena_top_q    <= '0;
			list_started_q <= 1'b0;
			limit_q        <= ffha_pkg::LIMIT_RESET;
			have_prev_q    <= 1'b0;
			res_ok_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_ok_q       <= 1'b0;
			out_off_q      <= '0;
		end else begin
			if (cfg_wen) begin
				limit_q <= cfg_wdata;
			end
			if (m_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					p_q         <= '0;
					have_prev_q <= 1'b0;
					res_off_q   <= '0;
					if (s_tvalid) begin
						if (s_tuser == ffha_pkg::OP_FREE) begin
							target_q <= alu_y[OFF_W-1:0];
							if (free_ok) begin
								state_q <= ST_F_WALK;
							end else begin
								res_ok_q <= 1'b0;
								state_q  <= ST_DONE;
							end
						end else begin
							nsize_q <= {alu_y[SZ_W:2], 2'b00};
							state_q <= list_started_q ? ST_A_WALK : ST_A_APP;
						end
					end
				end
				ST_A_WALK: begin
					if (a_fit) begin
						if (a_split) begin
							state_q <= ST_A_SPL1;
						end else begin
							res_ok_q  <= 1'b1;
							res_off_q <= p_data;
							state_q   <= ST_DONE;
						end
					end else if (a_stop) begin
						// hold p_q: it marks the last block for the append link
						state_q <= ST_A_APP;
					end else begin
						p_q <= alu_y[OFF_W-1:0];
					end
				end
				ST_A_SPL1: begin
					rem_q   <= alu_y[SZ_W-1:0];
					state_q <= ST_A_SPL2;
				end
				ST_A_SPL2: begin
					state_q <= ST_A_SPL3;
				end
				ST_A_SPL3: begin
					res_ok_q  <= 1'b1;
					res_off_q <= p_data;
					state_q   <= ST_DONE;
				end
				ST_A_APP: begin
					if (over) begin
						res_ok_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_A_NEW;
					end
				end
				ST_A_NEW: begin
					arena_top_q    <= alu_y[SZ_W-1:0];
					list_started_q <= 1'b1;
					res_ok_q       <= 1'b1;
					res_off_q      <= end_data;
					state_q        <= ST_DONE;
				end
				ST_F_WALK: begin
					if (f_hit) begin
						sz_q   <= sz;
						last_q <= rd_hdr_q.last;
						if (rd_hdr_q.used) begin
							state_q <= ST_F_MRG;
						end else begin
							res_ok_q <= 1'b0;
							state_q  <= ST_DONE;
						end
					end else if (f_stop) begin
						res_ok_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						prev_q      <= p_q;
						prev_hdr_q  <= rd_hdr_q;
						have_prev_q <= 1'b1;
						p_q         <= alu_y[OFF_W-1:0];
					end
				end
				ST_F_MRG: begin
					sz_q    <= mrg_size;
					last_q  <= mrg_last;
					state_q <= ST_F_PRV;
				end
				ST_F_PRV: begin
					res_ok_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					// load the result once the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_off_q   <= res_ok_q ? res_off_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("header read and write in the same cycle");

	a_arena_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(arena_top_q <= SZ_W'(ffha_pkg::ARENA_BYTES)) && (arena_top_q[1:0] == 2'b00))
		else $error("arena top beyond arena or unaligned");

	a_end_needs_list: assert property (@(posedge clk) disable iff (!arst_n)
		(arena_top_q != $past(arena_top_q)) |-> list_started_q)
		else $error("arena top moved without a block list");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again straight after a transfer");

	a_free_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_PRV) |=> (res_off_q == '0))
		else $error("free result carries a data offset");
`endif

endmodule
